// ===== rtl/mtds_pkg.sv =====
// Shared constants, register and state codes for the motion-to-drive-signal block.
// Used by the channel interfaces, the serial divider, the core and its checker.
package mtds_pkg;

  localparam int ONE_Q16    = 65536;
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 17;
  localparam int DISP_W     = 19;
  localparam int MAG_SHIFT  = 10;
  localparam int MAG_W      = DISP_W + MAG_SHIFT;
  localparam int FH_W       = 12;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = 17;
  localparam int HLEN_W     = 5;
  localparam int PROD_W     = FH_W + FRAC_W;
  localparam int RAVG_W     = Q_W + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam int TRACK_LEN_MAX_DEF = 16;
  localparam int MAX_TRACKS_DEF    = 256;

  localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST   = 12'd480;
  localparam logic [FRAC_W-1:0] THRESHOLD_FRAC_RST = 16'd66;
  localparam logic [FRAC_W-1:0] CUTOFF_FRAC_RST    = 16'd328;
  localparam logic [GAIN_W-1:0] MAX_VELOCITY_RST   = 17'd58982;
  localparam logic [HLEN_W-1:0] HISTORY_LEN_RST    = 5'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT   = 0,
    REG_THRESHOLD_FRAC = 1,
    REG_CUTOFF_FRAC    = 2,
    REG_MAX_VELOCITY   = 3,
    REG_HISTORY_LEN    = 4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_CUT,
    ST_CHECK,
    ST_NORM,
    ST_FRAME,
    ST_AVG,
    ST_PUSH,
    ST_SUM,
    ST_SDRAIN,
    ST_RDIV,
    ST_RAVG,
    ST_MUL,
    ST_POS
  } state_t;

  typedef struct packed {
    logic start;
    logic norm;
  } div_ctl_t;

endpackage

// ===== rtl/mtds_if.sv =====
// Valid/ready channel interfaces for the input, result and configuration items.
// Depends on mtds_pkg for the field widths.
interface mtds_in_if import mtds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] track_y_disp;
  logic                     last_in_frame;

  modport source (output valid, output track_y_disp, output last_in_frame, input ready);
  modport sink (input valid, input track_y_disp, input last_in_frame, output ready);
endinterface

interface mtds_out_if import mtds_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           direction;
  logic [Q_W-1:0] velocity;
  logic [Q_W-1:0] position;

  modport source (output valid, output direction, output velocity, output position,
                  input ready);
  modport sink (input valid, input direction, input velocity, input position,
                output ready);
endinterface

interface mtds_cfg_if import mtds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mtds_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, shared by the core.
// Depends on mtds_pkg for the divisor and quotient widths and the control struct.
module mtds_serial_div import mtds_pkg::*; #(
  parameter int DVD_W = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [PROD_W-1:0] rem_init,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [PROD_W-1:0] divisor,
  output logic              done,
  output logic [Q_W-1:0]    quot
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [PROD_W-1:0] dvs_r, dvs_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [PROD_W:0]   trial;
  logic [PROD_W:0]   diff;
  logic              fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      step_nxt = ctl.norm ? STEP_W'(Q_W) : STEP_W'(DVD_W);
      rem_nxt  = rem_init;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
      dvd_nxt  = dvd_r << 1;
      quo_nxt  = {quo_r[Q_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/motion_to_drive_signal_core.sv =====
// Top level of the motion-to-drive-signal block: deadband, clamp, frame average,
// rolling history and clamped integrator. Depends on mtds_pkg, mtds_if, mtds_serial_div.
// Flow: a track that falls in the deadband passes the threshold, cutoff and check states;
// a counted track, with the cutoff above the deadband, then waits for the 17 quotient bits
// of the serial divider. A frame-closing track adds two divider passes of DVD_W bits and
// one history read per window entry, plus any wait for the result register.
// One item at a time is in work.
// Reset (synchronous, rst_n low) restores the register defaults and empties the frame and
// history state at once; there is no clearing pass.
module motion_to_drive_signal_core import mtds_pkg::*; #(
  parameter int TRACK_LEN_MAX = TRACK_LEN_MAX_DEF,
  parameter int MAX_TRACKS    = MAX_TRACKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mtds_in_if.sink   in_chan,
  mtds_out_if.source out_chan,
  mtds_cfg_if.sink  cfg_chan
);

  // Widths that follow from the history depth and the track limit.
  localparam int HEAD_W = (TRACK_LEN_MAX > 1) ? $clog2(TRACK_LEN_MAX) : 1;
  localparam int FILL_W = $clog2(TRACK_LEN_MAX + 1);
  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int SMAG_W = $clog2(MAX_TRACKS * ONE_Q16 + 1);
  localparam int SUM_W  = SMAG_W + 1;
  localparam int WMAG_W = $clog2(TRACK_LEN_MAX * ONE_Q16 + 1);
  localparam int WSUM_W = WMAG_W + 1;
  localparam int DVD_W  = (SMAG_W > WMAG_W) ? SMAG_W : WMAG_W;
  localparam int POS_W  = Q_W + 2;

  // Configuration registers.
  logic [FH_W-1:0]   fh_r;
  logic [FRAC_W-1:0] thr_frac_r;
  logic [FRAC_W-1:0] cut_frac_r;
  logic [GAIN_W-1:0] gain_r;
  logic [HLEN_W-1:0] hlen_r;

  // Sequencer and control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [HEAD_W-1:0] idx_r, idx_nxt;
  logic [FILL_W-1:0] scnt_r, scnt_nxt;
  logic              rd_pend_r;
  logic              rd_zero_r;
  logic              ent0_valid_r, ent0_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] frame_sum_r, frame_sum_nxt;
  logic [Q_W-1:0]    pos_r, pos_nxt;

  // Per-item payload.
  logic signed [DISP_W-1:0] disp_r, disp_nxt;
  logic                     last_r, last_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic [PROD_W-1:0]        thr_r, thr_nxt;
  logic [PROD_W-1:0]        cut_r, cut_nxt;
  logic signed [RAVG_W-1:0] avg_r, avg_nxt;
  logic signed [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic signed [RAVG_W-1:0] ravg_r, ravg_nxt;
  logic [Q_W-1:0]           vel_r, vel_nxt;
  logic                     out_dir_r, out_dir_nxt;
  logic [Q_W-1:0]           out_vel_r, out_vel_nxt;
  logic [Q_W-1:0]           out_pos_r, out_pos_nxt;

  // History of frame averages. Only entry zero can be read before it is written, so a
  // single flag stands in for its reset value of zero.
  logic signed [RAVG_W-1:0] hist_mem [TRACK_LEN_MAX];
  logic signed [RAVG_W-1:0] hist_q_r;
  logic                     hist_we;
  logic                     in_accept;
  logic                     out_free;

  // Divider hookup.
  div_ctl_t          div_ctl;
  logic [PROD_W-1:0] div_rem;
  logic [DVD_W-1:0]  div_dvd;
  logic [PROD_W-1:0] div_dvs;
  logic              div_done;
  logic [Q_W-1:0]    div_quot;

  // Shared arithmetic.
  logic [PROD_W-1:0] frac_sel;
  logic [PROD_W-1:0] mul_prod;
  logic [DISP_W-1:0] disp_abs;
  logic              counted;
  logic [PROD_W-1:0] mag_clip;
  logic [PROD_W-1:0] span_a;
  logic [SUM_W-1:0]  sum_abs;
  logic [WSUM_W-1:0] wsum_abs;
  logic [RAVG_W-1:0] ravg_abs;
  logic [Q_W-1:0]    gain_sat;
  logic [2*Q_W-1:0]  vel_prod;
  logic signed [POS_W-1:0] pos_step;
  logic signed [POS_W-1:0] pos_sum;
  logic [Q_W-1:0]    pos_clamp;
  logic [FILL_W-1:0] len_c;
  logic [HEAD_W:0]   head_inc;

  assign in_accept = in_chan.valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_chan.ready;

  // One 12 by 16 multiplier gives the deadband in ST_THR and the cutoff in ST_CUT.
  assign frac_sel = (state_r == ST_THR) ? PROD_W'(thr_frac_r) : PROD_W'(cut_frac_r);
  assign mul_prod = PROD_W'(fh_r) * frac_sel;

  assign disp_abs = disp_r[DISP_W-1] ? (~disp_r + DISP_W'(1)) : disp_r;
  assign counted  = (mag_r > MAG_W'(thr_r)) && (count_r < CNT_W'(MAX_TRACKS));
  assign mag_clip = (mag_r > MAG_W'(cut_r)) ? cut_r : mag_r[PROD_W-1:0];
  assign span_a   = mag_clip - thr_r;

  assign sum_abs  = frame_sum_r[SUM_W-1] ? SUM_W'(-frame_sum_r) : SUM_W'(frame_sum_r);
  assign wsum_abs = wsum_r[WSUM_W-1] ? WSUM_W'(-wsum_r) : WSUM_W'(wsum_r);
  assign ravg_abs = ravg_r[RAVG_W-1] ? RAVG_W'(-ravg_r) : RAVG_W'(ravg_r);

  assign gain_sat = (gain_r > GAIN_W'(ONE_Q16)) ? Q_W'(ONE_Q16) : Q_W'(gain_r);
  assign vel_prod = (2*Q_W)'(gain_sat) * (2*Q_W)'(ravg_abs[Q_W-1:0]);

  assign pos_step = ravg_r[RAVG_W-1] ? -$signed(POS_W'(vel_r)) : $signed(POS_W'(vel_r));
  assign pos_sum  = $signed(POS_W'(pos_r)) + pos_step;
  assign pos_clamp = pos_sum[POS_W-1] ? '0 :
                     (pos_sum > $signed(POS_W'(ONE_Q16))) ? Q_W'(ONE_Q16) :
                     pos_sum[Q_W-1:0];

  // Window length: zero means one, and it never exceeds the history depth.
  assign len_c = (hlen_r == '0) ? FILL_W'(1) :
                 (int'(hlen_r) > TRACK_LEN_MAX) ? FILL_W'(TRACK_LEN_MAX) : FILL_W'(hlen_r);
  assign head_inc = {1'b0, head_r} + (HEAD_W+1)'(1);

  // Divider operands follow the state that starts it. The normalisation numerator is
  // (span << 16) with span no larger than the divisor, so the upper quotient bits are zero
  // and the division starts with span >> 1 already in the remainder.
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.norm  = 1'b0;
    case (state_r)
      ST_CHECK: begin
        div_rem = {1'b0, span_a[PROD_W-1:1]};
        div_dvd = {span_a[0], {(DVD_W-1){1'b0}}};
        div_dvs = cut_r - thr_r;
        div_ctl.start = counted && (cut_r > thr_r);
        div_ctl.norm  = 1'b1;
      end
      ST_FRAME: begin
        div_rem = '0;
        div_dvd = DVD_W'(sum_abs);
        div_dvs = PROD_W'(count_r);
        div_ctl.start = (count_r != '0);
      end
      default: begin
        div_rem = '0;
        div_dvd = DVD_W'(wsum_abs);
        div_dvs = PROD_W'(fill_r);
        div_ctl.start = (state_r == ST_RDIV);
      end
    endcase
  end

  mtds_serial_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Sequencer: next state, control and datapath values.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    scnt_nxt       = scnt_r;
    ent0_valid_nxt = ent0_valid_r;
    frame_sum_nxt  = frame_sum_r;
    pos_nxt        = pos_r;
    disp_nxt       = disp_r;
    last_nxt       = last_r;
    mag_nxt        = mag_r;
    thr_nxt        = thr_r;
    cut_nxt        = cut_r;
    avg_nxt        = avg_r;
    wsum_nxt       = wsum_r;
    ravg_nxt       = ravg_r;
    vel_nxt        = vel_r;
    hist_we        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_dir_nxt    = out_dir_r;
    out_vel_nxt    = out_vel_r;
    out_pos_nxt    = out_pos_r;

    // A history word read in the previous cycle is added here.
    if (rd_pend_r) begin
      wsum_nxt = wsum_r + (rd_zero_r ? WSUM_W'(0) : WSUM_W'(hist_q_r));
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          disp_nxt  = in_chan.track_y_disp;
          last_nxt  = in_chan.last_in_frame;
          state_nxt = ST_THR;
        end
      end
      ST_THR: begin
        thr_nxt   = mul_prod;
        mag_nxt   = MAG_W'(disp_abs) << MAG_SHIFT;
        state_nxt = ST_CUT;
      end
      ST_CUT: begin
        cut_nxt   = mul_prod;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (counted && (cut_r > thr_r)) begin
          state_nxt = ST_NORM;
        end else begin
          // A cutoff at or below the deadband makes every counted track full scale.
          if (counted) begin
            frame_sum_nxt = disp_r[DISP_W-1] ? frame_sum_r - SUM_W'(ONE_Q16)
                                             : frame_sum_r + SUM_W'(ONE_Q16);
            count_nxt     = count_r + CNT_W'(1);
          end
          state_nxt = last_r ? ST_FRAME : ST_IDLE;
        end
      end
      ST_NORM: begin
        if (div_done) begin
          frame_sum_nxt = disp_r[DISP_W-1] ? frame_sum_r - SUM_W'(div_quot)
                                           : frame_sum_r + SUM_W'(div_quot);
          count_nxt     = count_r + CNT_W'(1);
          state_nxt     = last_r ? ST_FRAME : ST_IDLE;
        end
      end
      ST_FRAME: begin
        if (count_r == '0) begin
          avg_nxt   = '0;
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          avg_nxt   = frame_sum_r[SUM_W-1] ? -$signed(RAVG_W'(div_quot))
                                           : $signed(RAVG_W'(div_quot));
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        head_nxt = (head_inc >= (HEAD_W+1)'(TRACK_LEN_MAX)) ? '0 : head_inc[HEAD_W-1:0];
        hist_we  = 1'b1;
        if (head_nxt == '0) begin
          ent0_valid_nxt = 1'b1;
        end
        fill_nxt      = ((FILL_W+1)'(fill_r) + (FILL_W+1)'(1) > (FILL_W+1)'(len_c)) ?
                        len_c : fill_r + FILL_W'(1);
        idx_nxt       = head_nxt;
        scnt_nxt      = '0;
        wsum_nxt      = '0;
        frame_sum_nxt = '0;
        count_nxt     = '0;
        state_nxt     = ST_SUM;
      end
      ST_SUM: begin
        // One history read a cycle, newest entry first, walking backwards round the ring.
        idx_nxt  = (idx_r == '0) ? HEAD_W'(TRACK_LEN_MAX - 1) : idx_r - HEAD_W'(1);
        scnt_nxt = scnt_r + FILL_W'(1);
        if (scnt_r == fill_r - FILL_W'(1)) begin
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        state_nxt = ST_RDIV;
      end
      ST_RDIV: begin
        state_nxt = ST_RAVG;
      end
      ST_RAVG: begin
        if (div_done) begin
          ravg_nxt  = wsum_r[WSUM_W-1] ? -$signed(RAVG_W'(div_quot))
                                       : $signed(RAVG_W'(div_quot));
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        vel_nxt   = vel_prod[FRAC_BITS +: Q_W];
        state_nxt = ST_POS;
      end
      ST_POS: begin
        // The position is committed together with the result, so a stalled output
        // register holds the sequencer here without stepping the integrator twice.
        if (out_free) begin
          pos_nxt       = pos_clamp;
          out_valid_nxt = 1'b1;
          out_dir_nxt   = !ravg_r[RAVG_W-1] && (ravg_r != '0);
          out_vel_nxt   = vel_r;
          out_pos_nxt   = pos_clamp;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      fill_r       <= FILL_W'(1);
      head_r       <= '0;
      idx_r        <= '0;
      scnt_r       <= '0;
      rd_pend_r    <= 1'b0;
      rd_zero_r    <= 1'b0;
      ent0_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      frame_sum_r  <= '0;
      pos_r        <= '0;
      fh_r         <= FRAME_HEIGHT_RST;
      thr_frac_r   <= THRESHOLD_FRAC_RST;
      cut_frac_r   <= CUTOFF_FRAC_RST;
      gain_r       <= MAX_VELOCITY_RST;
      hlen_r       <= HISTORY_LEN_RST;
    end else begin
      count_r      <= count_nxt;
      fill_r       <= fill_nxt;
      head_r       <= head_nxt;
      idx_r        <= idx_nxt;
      scnt_r       <= scnt_nxt;
      rd_pend_r    <= (state_r == ST_SUM);
      rd_zero_r    <= (idx_r == '0) && !ent0_valid_r;
      ent0_valid_r <= ent0_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      frame_sum_r  <= frame_sum_nxt;
      pos_r        <= pos_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          REG_FRAME_HEIGHT:   fh_r       <= cfg_chan.data[FH_W-1:0];
          REG_THRESHOLD_FRAC: thr_frac_r <= cfg_chan.data[FRAC_W-1:0];
          REG_CUTOFF_FRAC:    cut_frac_r <= cfg_chan.data[FRAC_W-1:0];
          REG_MAX_VELOCITY:   gain_r     <= cfg_chan.data[GAIN_W-1:0];
          REG_HISTORY_LEN:    hlen_r     <= cfg_chan.data[HLEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    disp_r    <= disp_nxt;
    last_r    <= last_nxt;
    mag_r     <= mag_nxt;
    thr_r     <= thr_nxt;
    cut_r     <= cut_nxt;
    avg_r     <= avg_nxt;
    wsum_r    <= wsum_nxt;
    ravg_r    <= ravg_nxt;
    vel_r     <= vel_nxt;
    out_dir_r <= out_dir_nxt;
    out_vel_r <= out_vel_nxt;
    out_pos_r <= out_pos_nxt;
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[head_nxt] <= avg_r;
    end
    hist_q_r <= hist_mem[idx_r];
  end

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign cfg_chan.ready     = 1'b1;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.direction = out_dir_r;
  assign out_chan.velocity  = out_vel_r;
  assign out_chan.position  = out_pos_r;

endmodule

// ===== rtl/mtds_checker.sv =====
// Port-level checks for the motion-to-drive-signal core, bound onto the top level.
// Depends on mtds_pkg for the field widths and the full-scale constant.
module mtds_checker import mtds_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic           out_direction,
  input logic [Q_W-1:0] out_velocity,
  input logic [Q_W-1:0] out_position
);

  // No result is offered in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result keeps its fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_direction, out_velocity, out_position}))
    else $error("stalled result changed");

  // Velocity and position never leave the range 0 to 1.0.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position <= Q_W'(ONE_Q16)) && (out_velocity <= Q_W'(ONE_Q16)))
    else $error("result out of range");

  // A new result is produced only by a frame in work, while input is held off.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the core was idle");

endmodule

bind motion_to_drive_signal_core mtds_checker u_mtds_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_direction (out_chan.direction),
  .out_velocity  (out_chan.velocity),
  .out_position  (out_chan.position)
);

// ===== sim/tb_motion_to_drive_signal_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for motion_to_drive_signal_core: directed tracks, then random frames
// over several register settings. Depends on mtds_pkg, the mtds_if channel interfaces and the RTL.
module tb_motion_to_drive_signal_core;
  import mtds_pkg::*;

  localparam int CLK_HALF      = 5;
  // A frame-closing track runs two long divider passes plus the window read; the settle
  // time comfortably covers any track still in work when the last result leaves.
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RANDOM_TRACKS = 280;
  localparam int PHASES        = 8;
  localparam int HOLD_PHASE    = 3;
  localparam int FLOOD_PHASE   = 4;
  localparam int FLOOD_TRACKS  = 270;
  localparam int DISP_MAX      = (1 << (DISP_W - 1)) - 1;

  typedef struct packed {
    logic           direction;
    logic [Q_W-1:0] velocity;
    logic [Q_W-1:0] position;
  } drive_t;

  // One row of the directed table. Where known is set, want holds the result typed in by
  // hand; otherwise the result comes from the predictor.
  typedef struct packed {
    logic signed [DISP_W-1:0] disp;
    logic                     last;
    logic                     known;
    drive_t                   want;
  } track_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mtds_in_if  in_if ();
  mtds_out_if out_if ();
  mtds_cfg_if cfg_if ();

  motion_to_drive_signal_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Register copies as the block should hold them.
  logic [FH_W-1:0]   frame_height_q;
  logic [FRAC_W-1:0] threshold_q;
  logic [FRAC_W-1:0] cutoff_q;
  logic [GAIN_W-1:0] gain_q;
  logic [HLEN_W-1:0] window_len_q;

  // Frame accumulator, rolling window of frame averages and the integrated position.
  longint window_avg [TRACK_LEN_MAX_DEF];
  int     window_fill;
  int     window_head;
  longint track_sum;
  int     track_count;
  longint drive_pos;

  drive_t     drive_expect_q [$];
  drive_t     drive_want;
  track_row_t directed_q [$];
  int         mismatches;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         no_gaps;
  int         hold_seq;
  int         hold_seen;
  int         hold_left;
  int         random_sent;
  int         phase_goal;

  always #CLK_HALF clk = ~clk;

  // Works out the result of one track, if it closes a frame, and moves the copied state on.
  function automatic bit predict_drive(input logic signed [DISP_W-1:0] disp, input logic last,
                                       output drive_t res);
    longint d, mag, thr, cut, n, frame_avg, wsum, ravg, ravg_mag, gain, vel, pos;
    int     len, idx;
    d   = disp;
    mag = (d < 0 ? -d : d) * 1024;
    thr = longint'(frame_height_q) * longint'(threshold_q);
    cut = longint'(frame_height_q) * longint'(cutoff_q);
    res = '0;
    // Tracks inside the deadband, and tracks past the per-frame cap, leave no trace.
    if (mag > thr && track_count < MAX_TRACKS_DEF) begin
      if (cut > thr) begin
        n = (((mag > cut ? cut : mag) - thr) * ONE_Q16) / (cut - thr);
      end else begin
        n = ONE_Q16;
      end
      track_sum   += (d < 0) ? -n : n;
      track_count += 1;
    end
    if (!last) return 1'b0;

    // Signed division in SystemVerilog truncates toward zero, as the block does.
    frame_avg   = (track_count != 0) ? track_sum / track_count : 0;
    track_sum   = 0;
    track_count = 0;

    len = window_len_q;
    if (len < 1) len = 1;
    if (len > TRACK_LEN_MAX_DEF) len = TRACK_LEN_MAX_DEF;
    window_head = (window_head + 1 >= TRACK_LEN_MAX_DEF) ? 0 : window_head + 1;
    window_avg[window_head] = frame_avg;
    window_fill = (window_fill + 1 > len) ? len : window_fill + 1;

    wsum = 0;
    idx  = window_head;
    for (int i = 0; i < window_fill; i++) begin
      wsum += window_avg[idx];
      idx = (idx == 0) ? TRACK_LEN_MAX_DEF - 1 : idx - 1;
    end
    ravg = wsum / window_fill;

    gain     = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
    ravg_mag = (ravg < 0) ? -ravg : ravg;
    vel      = (gain * ravg_mag) / ONE_Q16;
    pos      = drive_pos + ((ravg < 0) ? -vel : vel);
    if (pos < 0) pos = 0;
    if (pos > ONE_Q16) pos = ONE_Q16;
    drive_pos = pos;

    res.direction = (ravg > 0);
    res.velocity  = vel[Q_W-1:0];
    res.position  = pos[Q_W-1:0];
    return 1'b1;
  endfunction

  // Picks a displacement around the current deadband and cutoff, so that both edges are
  // hit often; a counted pick always lands clear of the deadband.
  function automatic logic signed [DISP_W-1:0] pick_disp(input bit counted);
    longint thr_px, cut_px, mag;
    logic [31:0] raw;
    thr_px = (longint'(frame_height_q) * longint'(threshold_q)) >> MAG_SHIFT;
    cut_px = (longint'(frame_height_q) * longint'(cutoff_q)) >> MAG_SHIFT;
    if (cut_px < thr_px) cut_px = thr_px;
    if (counted) begin
      mag = $urandom_range(DISP_MAX, int'(thr_px + 2 > DISP_MAX ? DISP_MAX : thr_px + 2));
    end else begin
      case ($urandom_range(0, 9))
        0: mag = 0;
        1: begin
          // Anything at all, so that every bit of the field toggles.
          raw = $urandom;
          return raw[DISP_W-1:0];
        end
        2, 3: mag = thr_px - 2 + $urandom_range(0, 4);
        4, 5: mag = cut_px - 2 + $urandom_range(0, 4);
        9: mag = $urandom_range(0, 15);
        default: mag = thr_px + $urandom_range(0, int'(cut_px - thr_px + 1));
      endcase
    end
    if (mag < 0) mag = 0;
    if (mag > DISP_MAX) mag = DISP_MAX;
    if ($urandom_range(0, 1) == 1) begin
      mag = (mag == DISP_MAX && $urandom_range(0, 3) == 0) ? -mag - 1 : -mag;
    end
    return mag[DISP_W-1:0];
  endfunction

  function automatic track_row_t track_row(input int disp, input logic last);
    track_row_t r;
    r       = '0;
    r.disp  = DISP_W'(disp);
    r.last  = last;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input track_row_t r);
    directed_q = {directed_q, r};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one track, with a random idle gap first, and records its expected result once
  // the block takes it. Entered and left at a falling edge; valid stays high on exit.
  task automatic send_track(input logic signed [DISP_W-1:0] disp, input logic last,
                            input logic known, input drive_t want);
    drive_t res;
    int     gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.track_y_disp  = disp;
    in_if.last_in_frame = last;
    in_if.valid         = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if (predict_drive(disp, last, res)) drive_expect_q = {drive_expect_q, known ? want : res};
    @(negedge clk);
  endtask

  // Sends one frame of random tracks, closing it with the frame flag on the last one.
  task automatic run_frame(input int ntracks, input bit counted);
    for (int i = 0; i < ntracks; i++) begin
      // Idling schedule: sender light and receiver heavy, then the reverse, then none.
      if (random_sent < 200) begin
        send_idle_pct = 20;
        recv_idle_pct = 72;
      end else if (random_sent < 400) begin
        send_idle_pct = 72;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_track(pick_disp(counted), (i == ntracks - 1), 1'b0, '0);
      random_sent++;
    end
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_FRAME_HEIGHT:   frame_height_q = data[FH_W-1:0];
      REG_THRESHOLD_FRAC: threshold_q    = data[FRAC_W-1:0];
      REG_CUTOFF_FRAC:    cutoff_q       = data[FRAC_W-1:0];
      REG_MAX_VELOCITY:   gain_q         = data[GAIN_W-1:0];
      REG_HISTORY_LEN:    window_len_q   = data[HLEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input int fh, input int thr, input int cut, input int gain,
                               input int hlen);
    program_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
    program_reg(REG_THRESHOLD_FRAC, CFG_DATA_W'(thr));
    program_reg(REG_CUTOFF_FRAC, CFG_DATA_W'(cut));
    program_reg(REG_MAX_VELOCITY, CFG_DATA_W'(gain));
    program_reg(REG_HISTORY_LEN, CFG_DATA_W'(hlen));
    cfg_if.valid = 1'b0;
  endtask

  // Holds the sender until every frame result is out, then lets any track that yields no
  // result finish its way through the block.
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every result taken by the receiver is matched against the oldest pending frame.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("result with no frame pending", out_if.position, 0);
      end else begin
        drive_want = drive_expect_q.pop_front();
        if (out_if.direction !== drive_want.direction)
          report_mismatch("direction", out_if.direction, drive_want.direction);
        if (out_if.velocity !== drive_want.velocity)
          report_mismatch("velocity", out_if.velocity, drive_want.velocity);
        if (out_if.position !== drive_want.position)
          report_mismatch("position", out_if.position, drive_want.position);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("motion_to_drive_signal_core test failed");
      $finish;
    end
  end

  initial begin
    track_row_t row;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.track_y_disp  = '0;
    in_if.last_in_frame = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    mismatches          = 0;
    cycle_count         = 0;
    no_gaps             = 1'b0;
    hold_seq            = 0;
    hold_seen           = 0;
    hold_left           = 0;
    random_sent         = 0;
    send_idle_pct       = 20;
    recv_idle_pct       = 72;

    frame_height_q = FRAME_HEIGHT_RST;
    threshold_q    = THRESHOLD_FRAC_RST;
    cutoff_q       = CUTOFF_FRAC_RST;
    gain_q         = MAX_VELOCITY_RST;
    window_len_q   = HISTORY_LEN_RST;
    foreach (window_avg[i]) window_avg[i] = 0;
    window_fill = 1;
    window_head = 0;
    track_sum   = 0;
    track_count = 0;
    drive_pos   = 0;

    // Directed table, run with the reset settings (deadband 31680, cutoff 157440 in Q.16
    // pixels). A zero frame straight after reset averages with the zero entry left by reset, so
    // every output field is plainly zero.
    row       = track_row(0, 1'b1);
    row.known = 1'b1;
    row.want  = '0;
    add_row(row);
    add_row(track_row(DISP_MAX, 1'b1));         // largest positive, clamped
    add_row(track_row(-DISP_MAX - 1, 1'b1));    // most negative, clamped
    add_row(track_row(1, 1'b0));                // well inside the deadband
    add_row(track_row(-1, 1'b1));               // frame with nothing counted
    add_row(track_row(30, 1'b0));               // just inside the deadband
    add_row(track_row(31, 1'b0));               // just past it, a very small value
    add_row(track_row(-31, 1'b1));
    add_row(track_row(153, 1'b0));              // just below the cutoff
    add_row(track_row(154, 1'b0));              // just above it
    add_row(track_row(-200, 1'b1));
    add_row(track_row(100, 1'b0));              // mixed signs in one frame
    add_row(track_row(-50, 1'b0));
    add_row(track_row(5000, 1'b0));
    add_row(track_row(-3000, 1'b1));
    // Full-scale frames drive the position up against its upper clamp, then back to zero.
    repeat (4) add_row(track_row(DISP_MAX, 1'b1));
    repeat (4) add_row(track_row(-DISP_MAX - 1, 1'b1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[i]) begin
      send_track(directed_q[i].disp, directed_q[i].last, directed_q[i].known,
                 directed_q[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        // Largest height and fractions: the cutoff sits on the threshold, so every
        // counted track is full scale; gain exactly 1.0 and the longest window.
        0: apply_setting(4095, 65535, 65535, ONE_Q16, TRACK_LEN_MAX_DEF);
        // Zero height makes every nonzero track full scale; the gain above 1.0 saturates
        // and a zero window length acts as one.
        1: apply_setting(0, 0, 1, (1 << GAIN_W) - 1, 0);
        // Smallest height, no deadband, zero gain, window length beyond the maximum.
        2: apply_setting(1, 0, 65535, 0, (1 << HLEN_W) - 1);
        3: apply_setting(FRAME_HEIGHT_RST, THRESHOLD_FRAC_RST, CUTOFF_FRAC_RST,
                         MAX_VELOCITY_RST, TRACK_LEN_MAX_DEF);
        // The window shrinks from sixteen entries to one.
        4: apply_setting(100, 2000, 40000, 40000, 1);
        7: apply_setting(FRAME_HEIGHT_RST, THRESHOLD_FRAC_RST, CUTOFF_FRAC_RST,
                         MAX_VELOCITY_RST, HISTORY_LEN_RST);
        default: begin
          phase_goal = $urandom_range(4000, 0);
          // Writes to indexes past the register list must leave every register alone.
          program_reg(CFG_IDX_W'($urandom_range(255, 5)), CFG_DATA_W'($urandom));
          apply_setting($urandom_range(4095, 1), phase_goal,
                        phase_goal + $urandom_range(60000, 1), $urandom_range(ONE_Q16, 0),
                        $urandom_range(TRACK_LEN_MAX_DEF, 1));
        end
      endcase

      if (p == HOLD_PHASE) begin
        // Receiver holds off for a long stretch while single-track frames keep coming,
        // so the pending result backs up and the block stops taking tracks.
        hold_seq++;
        no_gaps = 1'b1;
        repeat (24) run_frame(1, 1'b0);
        no_gaps = 1'b0;
      end
      if (p == FLOOD_PHASE) begin
        // More counted tracks than a frame may hold; the surplus must be ignored.
        run_frame(FLOOD_TRACKS, 1'b1);
      end

      phase_goal = random_sent + RANDOM_TRACKS / PHASES;
      while (random_sent < phase_goal) begin
        run_frame(($urandom_range(0, 9) == 0) ? $urandom_range(20, 9)
                                              : $urandom_range(8, 1), 1'b0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("motion_to_drive_signal_core test passed");
    end else begin
      $display("motion_to_drive_signal_core test failed");
    end
    $finish;
  end

endmodule
